// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: field widths, function
// codes, character codes and default screen geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // default screen geometry
   localparam int TCW_COLUMNS = 80;
   localparam int TCW_ROWS    = 25;

   // port field widths
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int POS_OUT_W = 11;
   localparam int CELL_W  = CHAR_W + ATTR_W;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_BACK  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

   // character and attribute codes
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
   localparam logic [CELL_W-1:0] RESET_CELL   = {RESET_ATTR, BLANK_CODE};

endpackage

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/tcw_wrap_adder.sv =====
// ----------------------------------------------------------------------------
// tcw_wrap_adder
// Modular address adder: maps a logical cell address onto the circular
// screen store by adding the top-row base and wrapping at the store size.
// ----------------------------------------------------------------------------
module tcw_wrap_adder #(
   parameter int CELLS = 2000
) (
   input  logic [$clog2(CELLS)-1:0] base,
   input  logic [$clog2(CELLS)-1:0] offset,
   output logic [$clog2(CELLS)-1:0] sum
);

   localparam int ADDR_W = $clog2(CELLS);

   logic [ADDR_W:0] raw_sum;

   // both operands stay below CELLS, so one compare and subtract wraps it
   always_comb begin
      raw_sum = {1'b0, base} + {1'b0, offset};
      if (raw_sum >= (ADDR_W+1)'(CELLS)) begin
         sum = ADDR_W'(raw_sum - (ADDR_W+1)'(CELLS));
      end else begin
         sum = raw_sum[ADDR_W-1:0];
      end
   end

endmodule

// ===== design/text_console_writer_unit.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console over a COLUMNS x ROWS store of character/attribute cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one word per command: func (put, backspace, clear, read),
//   char_code for put and cell_index for read. A word is taken when req_valid
//   is high and req_stall is low. rsp_* returns one word per command with the
//   cursor after the command and, for read, the cell contents.
//   csr_* writes the text attribute; csr_ready is always high.
// Store:
//   put and backspace write one cell; an in-range read asks the RAM, then
//   captures its registered word; newline, an out-of-range read and
//   backspace at the origin write nothing. A scroll blanks one row, one
//   cell a cycle through the single RAM write port, then rolls the top-row
//   base; clear writes every cell the same way. The store is circular, so
//   no rows are copied. Scroll, roll, read and cursor-write addresses share one adder.
// Reset:
//   the sequencer fills every cell with a space in attribute 0x0F while
//   req_stall is high; csr writes are taken meanwhile.
// Stall:
//   the result sits in an output register; a new command is taken while it
//   waits, and the next result holds in the sequencer until rsp_stall drops.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
   parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
   parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcw_pkg::ROW_OUT_W-1:0] rsp_cursor_row,
   output logic [tcw_pkg::COL_OUT_W-1:0] rsp_cursor_col,
   output logic [tcw_pkg::POS_OUT_W-1:0] rsp_cursor_position,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcw_pkg::ATTR_W-1:0]    rsp_cell_attribute,
   // attribute register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tcw_pkg::ATTR_W-1:0]    csr_text_attribute
);

   import tcw_pkg::*;

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int POS_W  = $clog2(CELLS + 1);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLUMNS + 1);

   // sequencer states
   localparam logic [3:0] S_INIT   = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_WRITE  = 4'd2;
   localparam logic [3:0] S_SCROLL = 4'd3;
   localparam logic [3:0] S_ROLL   = 4'd4;
   localparam logic [3:0] S_CLEAR  = 4'd5;
   localparam logic [3:0] S_RDREQ  = 4'd6;
   localparam logic [3:0] S_RDCAP  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] top_base_ff, top_base_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  row_base_ff, row_base_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              wr_pending_ff, wr_pending_in;

   // current command
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [CHAR_W-1:0]  rd_char_ff, rd_char_in;
   logic [ATTR_W-1:0]  rd_attr_ff, rd_attr_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ROW_OUT_W-1:0] rsp_row_ff, rsp_row_in;
   logic [COL_OUT_W-1:0] rsp_col_ff, rsp_col_in;
   logic [POS_OUT_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic [CHAR_W-1:0]    rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]    rsp_attr_ff, rsp_attr_in;

   // shared address adder and RAM port
   logic [ADDR_W-1:0] add_offset;
   logic [ADDR_W-1:0] add_sum;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CELL_W-1:0] ram_rd_data;
   logic [CELL_W-1:0] blank_cell;
   logic              req_take;

   assign blank_cell = {attr_ff, BLANK_CODE};
   assign req_take   = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   // pick the logical offset added to the top-row base
   always_comb begin
      case (state_ff)
         S_SCROLL: add_offset = cnt_ff;
         S_ROLL:   add_offset = ADDR_W'(COLUMNS);
         S_RDREQ:  add_offset = ADDR_W'(index_ff);
         default:  add_offset = pos_ff[ADDR_W-1:0];
      endcase
   end

   tcw_wrap_adder #(
      .CELLS (CELLS)
   ) u_adder (
      .base   (top_base_ff),
      .offset (add_offset),
      .sum    (add_sum)
   );

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (add_sum),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      top_base_in   = top_base_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      row_base_in   = row_base_ff;
      pos_in        = pos_ff;
      wr_pending_in = wr_pending_ff;
      func_in       = func_ff;
      char_in       = char_ff;
      index_in      = index_ff;
      rd_char_in    = rd_char_ff;
      rd_attr_in    = rd_attr_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = add_sum;
      ram_wr_data   = blank_cell;
      ram_rd_en     = 1'b0;

      // latch a new attribute whenever one is written
      attr_in = csr_valid ? csr_text_attribute : attr_ff;

      // drop the result word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            // fill the store with the reset cell, one entry a cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = RESET_CELL;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               func_in    = req_func;
               char_in    = req_char_code;
               index_in   = req_cell_index;
               rd_char_in = '0;
               rd_attr_in = '0;
               case (req_func)
                  FUNC_PUT: begin
                     if (req_char_code == NEWLINE_CODE ||
                         col_ff == COL_W'(COLUMNS)) begin
                        // newline, explicit or forced by a full row
                        col_in = '0;
                        if (row_ff < ROW_W'(ROWS - 1)) begin
                           row_in      = row_ff + 1'b1;
                           row_base_in = row_base_ff + POS_W'(COLUMNS);
                           pos_in      = row_base_ff + POS_W'(COLUMNS);
                           state_in    = (req_char_code == NEWLINE_CODE) ?
                                         S_DONE : S_WRITE;
                        end else begin
                           // last row: scroll, then maybe write
                           pos_in        = row_base_ff;
                           cnt_in        = '0;
                           wr_pending_in = (req_char_code != NEWLINE_CODE);
                           state_in      = S_SCROLL;
                        end
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  FUNC_BACK: begin
                     if (row_ff == '0 && col_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        // step back, wrapping to the prior row's last column
                        if (col_ff == '0) begin
                           row_in      = row_ff - 1'b1;
                           row_base_in = row_base_ff - POS_W'(COLUMNS);
                           col_in      = COL_W'(COLUMNS - 1);
                        end else begin
                           col_in = col_ff - 1'b1;
                        end
                        pos_in   = pos_ff - 1'b1;
                        state_in = S_WRITE;
                     end
                  end
                  FUNC_CLEAR: begin
                     cnt_in   = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     // read: out-of-range index returns zeros
                     if (32'(req_cell_index) < CELLS) begin
                        state_in = S_RDREQ;
                     end else begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_WRITE: begin
            ram_wr_en = 1'b1;
            if (func_ff == FUNC_PUT) begin
               ram_wr_data = {attr_ff, char_ff};
               col_in      = col_ff + 1'b1;
               pos_in      = pos_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_SCROLL: begin
            // blank the old top row, which becomes the new bottom row
            ram_wr_en = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(COLUMNS - 1)) begin
               cnt_in   = '0;
               state_in = S_ROLL;
            end
         end
         S_ROLL: begin
            // advance the top-row base by one row
            top_base_in = add_sum;
            state_in    = wr_pending_ff ? S_WRITE : S_DONE;
         end
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == ADDR_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = S_DONE;
            end
         end
         S_RDREQ: begin
            ram_rd_en = 1'b1;
            state_in  = S_RDCAP;
         end
         S_RDCAP: begin
            rd_char_in = ram_rd_data[CHAR_W-1:0];
            rd_attr_in = ram_rd_data[CELL_W-1:CHAR_W];
            state_in   = S_DONE;
         end
         S_DONE: begin
            // hand the result over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = ROW_OUT_W'(row_ff);
               rsp_col_in   = COL_OUT_W'(col_ff);
               rsp_pos_in   = POS_OUT_W'(pos_ff);
               rsp_char_in  = rd_char_ff;
               rsp_attr_in  = rd_attr_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         top_base_ff   <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         row_base_ff   <= '0;
         pos_ff        <= '0;
         attr_ff       <= RESET_ATTR;
         wr_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         top_base_ff   <= top_base_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         row_base_ff   <= row_base_in;
         pos_ff        <= pos_in;
         attr_ff       <= attr_in;
         wr_pending_ff <= wr_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      char_ff     <= char_in;
      index_ff    <= index_in;
      rd_char_ff  <= rd_char_in;
      rd_attr_ff  <= rd_attr_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cursor_col      = rsp_col_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_char       = rsp_char_ff;
   assign rsp_cell_attribute  = rsp_attr_ff;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: text console writer testbench
// Drives command words (put, backspace, clear, read) into the console and
// checks every cursor/cell report against a cycle-free shadow of the screen.
// The shadow tracks the cursor, a flat copy of all cells and the current
// text attribute. Both channels idle at random, and the attribute register
// is rewritten between phases once the console has drained.
// ----------------------------------------------------------------------------
module tb_top;
   import tcw_pkg::*;

   localparam int CELLS      = TCW_ROWS * TCW_COLUMNS;
   localparam int CYCLE_CAP  = 20_000_000; // whole-run guard, far above a slow run
   localparam int HOLD_AT    = 400;        // report count that starts the long hold-off
   localparam int HOLD_LEN   = 300;        // sets the length of the receiver hold-off
   localparam int IDLE_PCT   = 6;
   localparam int PHASE_LEN  = 300;        // least random commands per attribute setting

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CHAR_W-1:0]  char_code;
      logic [INDEX_W-1:0] cell_index;
   } console_cmd_type;

   typedef struct packed {
      logic [ROW_OUT_W-1:0] cursor_row;
      logic [COL_OUT_W-1:0] cursor_col;
      logic [POS_OUT_W-1:0] cursor_position;
      logic [CHAR_W-1:0]    cell_char;
      logic [ATTR_W-1:0]    cell_attribute;
   } console_report_type;

   // ---------------------------------------------------------------------
   // clock, reset and DUT ports; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_PUT;
   logic [CHAR_W-1:0]    req_char_code = '0;
   logic [INDEX_W-1:0]   req_cell_index = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ROW_OUT_W-1:0] rsp_cursor_row;
   logic [COL_OUT_W-1:0] rsp_cursor_col;
   logic [POS_OUT_W-1:0] rsp_cursor_position;
   logic [CHAR_W-1:0]    rsp_cell_char;
   logic [ATTR_W-1:0]    rsp_cell_attribute;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ATTR_W-1:0]    csr_text_attribute = RESET_ATTR;

   always #4 clock = ~clock;

   text_console_writer_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_func            (req_func),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cursor_col      (rsp_cursor_col),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_char       (rsp_cell_char),
      .rsp_cell_attribute  (rsp_cell_attribute),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_text_attribute  (csr_text_attribute)
   );

   // ---------------------------------------------------------------------
   // shared bookkeeping
   // ---------------------------------------------------------------------
   console_cmd_type    cmd_backlog[$];     // commands waiting to be offered
   console_report_type cursor_reports[$];  // predicted reports, oldest first
   logic [ATTR_W-1:0]  attr_backlog[$];    // attribute writes waiting

   int unsigned error_count    = 0;
   int unsigned accepted_words = 0;
   int unsigned checked_words  = 0;
   int unsigned cycle_count    = 0;
   int unsigned attr_settings  = 0;
   int unsigned n_put = 0, n_newline = 0, n_back = 0, n_clear = 0, n_read = 0;
   int unsigned scroll_count = 0, wrap_count = 0;

   // ---------------------------------------------------------------------
   // screen shadow: cursor, all cells, current attribute
   // ---------------------------------------------------------------------
   logic [CELL_W-1:0] screen_shadow [CELLS];
   int unsigned       cur_row;
   int unsigned       cur_col;
   logic [ATTR_W-1:0] cur_attr;

   // Move to column 0 of the next row; on the bottom row shift every row up
   // and blank the bottom one instead.
   function automatic void advance_line();
      cur_col = 0;
      if (cur_row < TCW_ROWS - 1) begin
         cur_row++;
      end else begin
         for (int i = 0; i < CELLS - TCW_COLUMNS; i++)
            screen_shadow[i] = screen_shadow[i + TCW_COLUMNS];
         for (int i = CELLS - TCW_COLUMNS; i < CELLS; i++)
            screen_shadow[i] = {cur_attr, BLANK_CODE};
         scroll_count++;
      end
   endfunction

   // Apply one command to the shadow and build the report it must produce.
   function automatic console_report_type console_step(console_cmd_type c);
      console_report_type r;
      r = '0;
      case (c.func)
         FUNC_PUT: begin
            if (c.char_code == NEWLINE_CODE) begin
               n_newline++;
               advance_line();
            end else begin
               n_put++;
               // past the end of the row: wrap first, possibly scrolling
               if (cur_col >= TCW_COLUMNS) begin
                  wrap_count++;
                  advance_line();
               end
               screen_shadow[cur_row * TCW_COLUMNS + cur_col] = {cur_attr, c.char_code};
               cur_col++;
            end
         end
         FUNC_BACK: begin
            n_back++;
            // nothing moves at the origin
            if (cur_row * TCW_COLUMNS + cur_col > 0) begin
               if (cur_col == 0) begin
                  cur_row--;
                  cur_col = TCW_COLUMNS - 1;
               end else begin
                  cur_col--;
               end
               screen_shadow[cur_row * TCW_COLUMNS + cur_col] = {cur_attr, BLANK_CODE};
            end
         end
         FUNC_CLEAR: begin
            n_clear++;
            for (int i = 0; i < CELLS; i++)
               screen_shadow[i] = {cur_attr, BLANK_CODE};
         end
         default: begin
            // read; out-of-range reads come back as zero
            n_read++;
            if (c.cell_index < CELLS) begin
               r.cell_char      = screen_shadow[c.cell_index][CHAR_W-1:0];
               r.cell_attribute = screen_shadow[c.cell_index][CELL_W-1:CHAR_W];
            end
         end
      endcase
      r.cursor_row      = ROW_OUT_W'(cur_row);
      r.cursor_col      = COL_OUT_W'(cur_col);
      r.cursor_position = POS_OUT_W'(cur_row * TCW_COLUMNS + cur_col);
      return r;
   endfunction

   function automatic bit idle_draw();
      return $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   // ---------------------------------------------------------------------
   // command driver: offer the head of the backlog, hold it while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      console_cmd_type taken;
      bit              stalled;
      bit              quiet;
      stalled = req_valid && req_stall;
      // no idling at all across a stretch in the middle of the run
      quiet = accepted_words >= 900 && accepted_words < 1300;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            // predict at acceptance so the shadow follows the DUT's order
            taken = '{req_func, req_char_code, req_cell_index};
            cursor_reports.push_back(console_step(taken));
            void'(cmd_backlog.pop_front());
            accepted_words++;
         end
         // a stalled word stays on the bus untouched
         if (!stalled) begin
            if (cmd_backlog.size() != 0 && (quiet || !idle_draw())) begin
               req_valid      <= 1'b1;
               req_func       <= cmd_backlog[0].func;
               req_char_code  <= cmd_backlog[0].char_code;
               req_cell_index <= cmd_backlog[0].cell_index;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // attribute register writer; only fed while the console is idle
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            cur_attr = csr_text_attribute;
            void'(attr_backlog.pop_front());
            attr_settings++;
         end
         if (!(csr_valid && !csr_ready)) begin
            if (attr_backlog.size() != 0) begin
               csr_valid          <= 1'b1;
               csr_text_attribute <= attr_backlog[0];
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // report monitor
   // ---------------------------------------------------------------------
   int unsigned rsp_hold_left = 0;
   bit          rsp_hold_done = 1'b0;

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      console_report_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (cursor_reports.size() == 0) begin
               $error("report word arrived with nothing outstanding");
               error_count++;
            end else begin
               want = cursor_reports.pop_front();
               check_field("cursor_row",      want.cursor_row,      rsp_cursor_row);
               check_field("cursor_col",      want.cursor_col,      rsp_cursor_col);
               check_field("cursor_position", want.cursor_position, rsp_cursor_position);
               check_field("cell_char",       want.cell_char,       rsp_cell_char);
               check_field("cell_attribute",  want.cell_attribute,  rsp_cell_attribute);
            end
            checked_words++;
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver stall
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      bit hold_next;
      bit quiet;
      quiet = checked_words >= 900 && checked_words < 1300;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         // one long hold-off so the console backs up and stalls its input
         if (rsp_hold_left != 0) begin
            rsp_hold_left--;
            hold_next = 1'b1;
         end else if (checked_words >= HOLD_AT && !rsp_hold_done) begin
            rsp_hold_left = HOLD_LEN;
            rsp_hold_done = 1'b1;
            hold_next     = 1'b1;
         end else begin
            hold_next = quiet ? 1'b0 : idle_draw();
         end
         rsp_stall <= hold_next;
      end
   end

   // ---------------------------------------------------------------------
   // run guard
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_CAP) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   function automatic void push_cmd(logic [FUNC_W-1:0] f, logic [CHAR_W-1:0] ch,
                                    logic [INDEX_W-1:0] idx);
      cmd_backlog.push_back('{f, ch, idx});
   endfunction

   function automatic logic [CHAR_W-1:0] plain_char();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255)); while (c == NEWLINE_CODE);
      return c;
   endfunction

   function automatic logic [INDEX_W-1:0] any_index();
      // mostly on screen, now and then past the last cell
      if ($urandom_range(0, 99) < 85)
         return INDEX_W'($urandom_range(0, CELLS - 1));
      return INDEX_W'($urandom_range(CELLS, (1 << INDEX_W) - 1));
   endfunction

   // Queue one random stretch of commands; return how many were queued.
   function automatic int queue_random_stretch();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      n    = 1;
      if (pick < 6) begin
         // long text run: walks off the end of the row and wraps
         n = $urandom_range(60, 100);
         repeat (n) push_cmd(FUNC_PUT, plain_char(), any_index());
      end else if (pick < 9) begin
         // newline burst: reaches the bottom row and scrolls
         n = $urandom_range(5, 30);
         repeat (n) push_cmd(FUNC_PUT, NEWLINE_CODE, any_index());
      end else if (pick < 12) begin
         // backspace burst: crosses row starts, sometimes back to the origin
         n = $urandom_range(1, 120);
         repeat (n) push_cmd(FUNC_BACK, CHAR_W'($urandom), any_index());
      end else if (pick < 14) begin
         push_cmd(FUNC_CLEAR, CHAR_W'($urandom), any_index());
      end else if (pick < 50) begin
         push_cmd(FUNC_PUT, CHAR_W'($urandom), any_index());
      end else if (pick < 60) begin
         push_cmd(FUNC_PUT, NEWLINE_CODE, any_index());
      end else if (pick < 72) begin
         push_cmd(FUNC_BACK, CHAR_W'($urandom), any_index());
      end else begin
         push_cmd(FUNC_READ, CHAR_W'($urandom), any_index());
      end
      return n;
   endfunction

   // Hold until every command is taken, every report checked and every
   // attribute write done.
   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || cursor_reports.size() != 0 ||
             attr_backlog.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [ATTR_W-1:0] phase_attr [6];
      int                queued;

      for (int i = 0; i < CELLS; i++)
         screen_shadow[i] = RESET_CELL;
      cur_row  = 0;
      cur_col  = 0;
      cur_attr = RESET_ATTR;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, under the reset attribute: screen corners and
      // out-of-range reads, backspace at the origin, extreme characters,
      // backspace from column 0 and from past the end, wrap, clear.
      push_cmd(FUNC_READ,  8'h00, 11'd0);
      push_cmd(FUNC_READ,  8'hFF, 11'd1999);
      push_cmd(FUNC_READ,  8'h00, 11'd2000);
      push_cmd(FUNC_READ,  8'hFF, 11'd2047);
      push_cmd(FUNC_BACK,  8'hFF, 11'd2047);
      push_cmd(FUNC_PUT,   8'h41, 11'd0);
      push_cmd(FUNC_PUT,   8'h00, 11'd0);
      push_cmd(FUNC_PUT,   8'hFF, 11'd2047);
      push_cmd(FUNC_BACK,  8'h00, 11'd0);
      push_cmd(FUNC_PUT,   NEWLINE_CODE, 11'd0);
      push_cmd(FUNC_BACK,  8'h00, 11'd0);
      push_cmd(FUNC_PUT,   8'h78, 11'd0);
      push_cmd(FUNC_BACK,  8'h00, 11'd0);
      push_cmd(FUNC_PUT,   8'h79, 11'd0);
      push_cmd(FUNC_PUT,   8'h7A, 11'd0);
      push_cmd(FUNC_READ,  8'h00, 11'd79);
      push_cmd(FUNC_READ,  8'h00, 11'd80);
      push_cmd(FUNC_READ,  8'h00, 11'd1);
      push_cmd(FUNC_CLEAR, 8'hFF, 11'd2047);
      push_cmd(FUNC_READ,  8'h00, 11'd80);
      push_cmd(FUNC_READ,  8'h00, 11'd0);
      wait_drained();

      // Random part: one attribute setting per phase, extremes first.
      phase_attr[0] = 8'hFF;
      phase_attr[1] = 8'h00;
      phase_attr[2] = ATTR_W'($urandom);
      phase_attr[3] = ATTR_W'($urandom);
      phase_attr[4] = RESET_ATTR;
      phase_attr[5] = ATTR_W'($urandom);
      foreach (phase_attr[p]) begin
         // write only on a drained console, and only queue work once it landed
         attr_backlog.push_back(phase_attr[p]);
         while (attr_backlog.size() != 0) @(negedge clock);
         queued = 0;
         while (queued < PHASE_LEN) queued += queue_random_stretch();
         wait_drained();
      end

      // allow for any stray report after the last one
      repeat (100) @(negedge clock);

      $display("covered %0d words: %0d puts, %0d newlines, %0d backspaces, %0d clears, %0d reads",
               accepted_words, n_put, n_newline, n_back, n_clear, n_read);
      $display("%0d scrolls, %0d wraps past row end, %0d attribute settings, %0d errors",
               scroll_count, wrap_count, attr_settings, error_count);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== text_console_writer_unit.f =====
design/tcw_pkg.sv
design/tcw_ram.sv
design/tcw_wrap_adder.sv
design/text_console_writer_unit.sv
dv/tb_top.sv
